// File: sv/ipd_pkg.sv
package ipd_pkg;

   // Mnemonic numbers.
   localparam logic [6:0] MN_ADC   = 7'd0;
   localparam logic [6:0] MN_CMP   = 7'd7;
   localparam logic [6:0] MN_CALL  = 7'd8;
   localparam logic [6:0] MN_DCR   = 7'd9;
   localparam logic [6:0] MN_ADI   = 7'd10;
   localparam logic [6:0] MN_CPI   = 7'd17;
   localparam logic [6:0] MN_DAD   = 7'd21;
   localparam logic [6:0] MN_DCX   = 7'd22;
   localparam logic [6:0] MN_HLT   = 7'd25;
   localparam logic [6:0] MN_INR   = 7'd26;
   localparam logic [6:0] MN_INX   = 7'd27;
   localparam logic [6:0] MN_LDA   = 7'd28;
   localparam logic [6:0] MN_LDAX  = 7'd29;
   localparam logic [6:0] MN_LHLD  = 7'd30;
   localparam logic [6:0] MN_LXI   = 7'd31;
   localparam logic [6:0] MN_MOV   = 7'd32;
   localparam logic [6:0] MN_MVI   = 7'd33;
   localparam logic [6:0] MN_MVR   = 7'd34;
   localparam logic [6:0] MN_UNDEF = 7'd36;
   localparam logic [6:0] MN_POP   = 7'd38;
   localparam logic [6:0] MN_PUSH  = 7'd40;
   localparam logic [6:0] MN_RST   = 7'd47;
   localparam logic [6:0] MN_JMP   = 7'd56;
   localparam logic [6:0] MN_CM    = 7'd72;
   localparam logic [6:0] MN_SHLD  = 7'd73;
   localparam logic [6:0] MN_STA   = 7'd75;
   localparam logic [6:0] MN_STAX  = 7'd76;
   localparam logic [6:0] MN_OUT   = 7'd80;
   localparam logic [6:0] MN_IN    = 7'd81;

   localparam logic [7:0] OP_HLT = 8'o166;
   localparam logic [2:0] REG_M  = 3'd6;

   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   localparam logic [6:0] LOW_MAP [64] = '{
      7'd35, 7'd31, 7'd76, 7'd27, 7'd26, 7'd9,  7'd33, 7'd42,
      7'd36, 7'd21, 7'd29, 7'd22, 7'd26, 7'd9,  7'd33, 7'd43,
      7'd36, 7'd31, 7'd76, 7'd27, 7'd26, 7'd9,  7'd33, 7'd44,
      7'd36, 7'd21, 7'd29, 7'd22, 7'd26, 7'd9,  7'd33, 7'd45,
      7'd36, 7'd31, 7'd73, 7'd27, 7'd26, 7'd9,  7'd33, 7'd20,
      7'd36, 7'd21, 7'd30, 7'd22, 7'd26, 7'd9,  7'd33, 7'd18,
      7'd36, 7'd31, 7'd75, 7'd27, 7'd26, 7'd9,  7'd33, 7'd77,
      7'd36, 7'd21, 7'd28, 7'd22, 7'd26, 7'd9,  7'd33, 7'd19
   };

   localparam logic [6:0] HIGH_MAP [64] = '{
      7'd48, 7'd38, 7'd57, 7'd56, 7'd65, 7'd40, 7'd10, 7'd47,
      7'd49, 7'd46, 7'd58, 7'd36, 7'd66, 7'd8,  7'd11, 7'd47,
      7'd50, 7'd38, 7'd59, 7'd80, 7'd67, 7'd40, 7'd12, 7'd47,
      7'd51, 7'd36, 7'd60, 7'd81, 7'd68, 7'd36, 7'd13, 7'd47,
      7'd52, 7'd38, 7'd61, 7'd78, 7'd69, 7'd40, 7'd14, 7'd47,
      7'd53, 7'd37, 7'd62, 7'd79, 7'd70, 7'd36, 7'd15, 7'd47,
      7'd54, 7'd39, 7'd63, 7'd23, 7'd71, 7'd41, 7'd16, 7'd47,
      7'd55, 7'd74, 7'd64, 7'd24, 7'd72, 7'd36, 7'd17, 7'd47
   };

   // ALU group by opcode bits 5:3: ADD ADC SUB SBB ANA XRA ORA CMP.
   localparam logic [6:0] ALU_MAP [8] = '{
      7'd1, 7'd0, 7'd3, 7'd2, 7'd4, 7'd5, 7'd6, 7'd7
   };

   // One gathered instruction on its way from the front to the back.
   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  opcode;
      logic [6:0]  mnemonic;
      logic [15:0] operand;
   } entry_type;

   function automatic logic [6:0] mnemonic_of(input logic [7:0] op);
      logic [6:0] mn;
      case (op[7:6])
         2'b00: mn = LOW_MAP[op[5:0]];
         2'b01: begin
            if (op == OP_HLT) begin
               mn = MN_HLT;
            end else if (op[2:0] == REG_M) begin
               mn = MN_MVR;
            end else begin
               mn = MN_MOV;
            end
         end
         2'b10: mn = ALU_MAP[op[5:3]];
         default: mn = HIGH_MAP[op[5:0]];
      endcase
      return mn;
   endfunction

   function automatic logic [1:0] length_of(input logic [6:0] mn);
      logic [1:0] len;
      if (mn inside {MN_CALL, MN_LDA, MN_LHLD, MN_LXI, MN_SHLD, MN_STA, [MN_JMP:MN_CM]}) begin
         len = LEN_THREE;
      end else if (mn inside {[MN_ADI:MN_CPI], MN_MVI, MN_OUT, MN_IN}) begin
         len = LEN_TWO;
      end else begin
         len = LEN_ONE;
      end
      return len;
   endfunction

endpackage

// File: sv/i8080_instruction_predecoder.sv
// 8080 instruction predecoder.
// Program bytes enter one per request on req_code_byte, in address order.
// The front gathers each instruction of one, two or three bytes and emits a
// request with one decoded record on the rsp_ channel once its last byte
// has been taken; opcode and first operand bytes of longer instructions
// produce nothing. Throughput is one byte per cycle, back to back, while
// req_stall is low. The record of a finished instruction is registered
// first into the four-entry queue between front and back, then into the
// output register that drives rsp_valid. req_stall rises only when that
// queue is full, which happens only after the receiver has held rsp_stall; a
// stalled result stays in the output register while the front keeps gathering.
// csr_wr_en loads csr_start_address as the address of the next byte and
// drops any partly gathered instruction; write it only while idle.
// Reset is synchronous: the next address becomes zero, the front expects an
// opcode, and the queue and output register are empty.
module i8080_instruction_predecoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_instr_address,
   output logic [7:0]  rsp_opcode,
   output logic [6:0]  rsp_mnemonic,
   output logic [2:0]  rsp_first_reg,
   output logic [2:0]  rsp_second_reg,
   output logic [15:0] rsp_operand_value,
   output logic [1:0]  rsp_length,
   output logic        rsp_undefined,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_start_address
);

   logic               accept;
   logic               push;
   logic               pop;
   logic               full;
   logic               head_valid;
   ipd_pkg::entry_type push_entry;
   ipd_pkg::entry_type head_entry;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   ipd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .code_byte         (req_code_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_start_address (csr_start_address),
      .push              (push),
      .push_entry        (push_entry)
   );

   ipd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ipd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_instr_address (rsp_instr_address),
      .rsp_opcode        (rsp_opcode),
      .rsp_mnemonic      (rsp_mnemonic),
      .rsp_first_reg     (rsp_first_reg),
      .rsp_second_reg    (rsp_second_reg),
      .rsp_operand_value (rsp_operand_value),
      .rsp_length        (rsp_length),
      .rsp_undefined     (rsp_undefined)
   );

   // The front must never complete an instruction into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("instruction completed while queue full");

   a_undef_matches_mnemonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_undefined == (rsp_mnemonic == ipd_pkg::MN_UNDEF)))
      else $error("undefined flag disagrees with mnemonic");

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length != 2'd0))
      else $error("result with zero length");

   // An undefined opcode is always a single byte.
   a_undef_one_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_undefined) |-> (rsp_length == ipd_pkg::LEN_ONE))
      else $error("undefined opcode with operand bytes");

endmodule

// File: sv/ipd_front.sv
module ipd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           code_byte,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_start_address,
   output logic                 push,
   output ipd_pkg::entry_type   push_entry
);

   logic [15:0] next_addr_ff, next_addr_in;
   logic [1:0]  pending_ff, pending_in;
   logic [15:0] op_addr_ff, op_addr_in;
   logic [7:0]  op_ff, op_in;
   logic [6:0]  mn_ff, mn_in;
   logic        word_ff, word_in;
   logic [7:0]  low_ff, low_in;

   logic [6:0]  byte_mn;
   logic [1:0]  byte_len;

   assign byte_mn  = ipd_pkg::mnemonic_of(code_byte);
   assign byte_len = ipd_pkg::length_of(byte_mn);

   always_comb begin
      next_addr_in = next_addr_ff;
      pending_in   = pending_ff;
      op_addr_in   = op_addr_ff;
      op_in        = op_ff;
      mn_in        = mn_ff;
      word_in      = word_ff;
      low_in       = low_ff;
      push         = 1'b0;
      push_entry   = '{addr: next_addr_ff, opcode: code_byte, mnemonic: byte_mn,
                       operand: 16'd0};
      if (csr_wr_en) begin
         next_addr_in = csr_start_address;
         pending_in   = 2'd0;
      end else if (accept) begin
         next_addr_in = next_addr_ff + 16'd1;
         case (pending_ff)
            2'd0: begin
               if (byte_len == ipd_pkg::LEN_ONE) begin
                  push = 1'b1;
               end else begin
                  op_addr_in = next_addr_ff;
                  op_in      = code_byte;
                  mn_in      = byte_mn;
                  word_in    = (byte_len == ipd_pkg::LEN_THREE);
                  pending_in = byte_len - 2'd1;
               end
            end
            2'd2: begin
               low_in     = code_byte;
               pending_in = 2'd1;
            end
            default: begin
               // Last operand byte completes the instruction.
               push       = 1'b1;
               push_entry = '{addr: op_addr_ff, opcode: op_ff, mnemonic: mn_ff,
                              operand: word_ff ? {code_byte, low_ff} : {8'd0, code_byte}};
               pending_in = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_addr_ff <= 16'd0;
         pending_ff   <= 2'd0;
      end else begin
         next_addr_ff <= next_addr_in;
         pending_ff   <= pending_in;
      end
      op_addr_ff <= op_addr_in;
      op_ff      <= op_in;
      mn_ff      <= mn_in;
      word_ff    <= word_in;
      low_ff     <= low_in;
   end

endmodule

// File: sv/ipd_queue.sv
module ipd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ipd_pkg::entry_type   push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output ipd_pkg::entry_type   head_entry
);

   localparam int PW = ipd_pkg::QPTR_WIDTH;

   ipd_pkg::entry_type entry_ff [ipd_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == (PW+1)'(ipd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/ipd_back.sv
module ipd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  ipd_pkg::entry_type   head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_instr_address,
   output logic [7:0]           rsp_opcode,
   output logic [6:0]           rsp_mnemonic,
   output logic [2:0]           rsp_first_reg,
   output logic [2:0]           rsp_second_reg,
   output logic [15:0]          rsp_operand_value,
   output logic [1:0]           rsp_length,
   output logic                 rsp_undefined
);

   logic        valid_ff, valid_in;
   logic [15:0] addr_ff;
   logic [7:0]  op_ff;
   logic [6:0]  mn_ff;
   logic [2:0]  r1_ff, r1_in;
   logic [2:0]  r2_ff, r2_in;
   logic [15:0] operand_ff, operand_in;
   logic [1:0]  len_ff;
   logic        undef_ff;

   logic [7:0]  op;
   logic [6:0]  mn;

   assign op  = head_entry.opcode;
   assign mn  = head_entry.mnemonic;
   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      r1_in      = 3'd0;
      r2_in      = 3'd0;
      operand_in = head_entry.operand;
      if (mn inside {ipd_pkg::MN_DCR, ipd_pkg::MN_INR, ipd_pkg::MN_MVI,
                     ipd_pkg::MN_MOV, ipd_pkg::MN_MVR}) begin
         r1_in = op[5:3];
      end else if (mn inside {ipd_pkg::MN_DAD, ipd_pkg::MN_DCX, ipd_pkg::MN_INX,
                              ipd_pkg::MN_LDAX, ipd_pkg::MN_LXI, ipd_pkg::MN_POP,
                              ipd_pkg::MN_PUSH, ipd_pkg::MN_STAX}) begin
         r1_in = {1'b0, op[5:4]};
      end
      if (mn inside {[ipd_pkg::MN_ADC:ipd_pkg::MN_CMP], ipd_pkg::MN_MOV,
                     ipd_pkg::MN_MVR}) begin
         r2_in = op[2:0];
      end
      // The restart vector is the opcode's middle field, left in place.
      if (mn == ipd_pkg::MN_RST) begin
         operand_in = {10'd0, op[5:3], 3'd0};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         addr_ff    <= head_entry.addr;
         op_ff      <= op;
         mn_ff      <= mn;
         r1_ff      <= r1_in;
         r2_ff      <= r2_in;
         operand_ff <= operand_in;
         len_ff     <= ipd_pkg::length_of(mn);
         undef_ff   <= (mn == ipd_pkg::MN_UNDEF);
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_instr_address = addr_ff;
   assign rsp_opcode        = op_ff;
   assign rsp_mnemonic      = mn_ff;
   assign rsp_first_reg     = r1_ff;
   assign rsp_second_reg    = r2_ff;
   assign rsp_operand_value = operand_ff;
   assign rsp_length        = len_ff;
   assign rsp_undefined     = undef_ff;

endmodule
